// ===== design/two_link_arm_inverse_kinematics_core_assert.svh =====
// assertion macros for the port-level inverse kinematics checker
// expects signals named clock and reset in the scope of use
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_CORE_ASSERT_SVH

// same-cycle implication
`define IKIN_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ikin assertion failed");

// next-cycle implication
`define IKIN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ikin assertion failed");

`endif

// ===== design/ikin_pkg.sv =====
// shared widths, constants and the cordic arctangent table
// for the two-link arm inverse kinematics core; no dependencies
`timescale 1ns / 1ps
package ikin_pkg;

   localparam int COORD_W = 14;
   localparam int ANGLE_W = 18;
   localparam int MOVE_W  = 19;
   localparam int OPND_W  = 27;   // multiplier and cordic operand width
   localparam int RAD_W   = 50;   // square root radicand width
   localparam int ROOT_W  = RAD_W / 2;
   localparam int CVEC_W  = 50;   // cordic vector width
   localparam int ZANG_W  = 26;   // angle in 2^-16 degree
   localparam int CSTEPS  = 17;

   localparam logic signed [ZANG_W-1:0] DEG180 = 26'sd11796480;
   localparam logic signed [ANGLE_W-1:0] RESET_UPPER = 18'sd5852;
   localparam logic signed [ANGLE_W-1:0] RESET_FORE  = 18'sd23040;

   function automatic logic [22:0] atan_entry(input logic [4:0] idx);
      logic [22:0] v;
      unique case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117304;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/two_link_arm_inverse_kinematics_core.sv =====
// two-link planar arm inverse kinematics core
// input channel req_*: target x and y in 1/16 mm, valid/stall handshake
// result channel rsp_*: reachable flag, new upper and forearm angles and the
//   moves from the stored angles, all angles in 1/256 degree
// a transfer on req_ happens when req_valid is high and req_stall is low
// one item at a time: req_stall stays high from the accepting edge until the
//   result is loaded into the rsp_ output register
// sequence: a reachable target runs the shared multiplier (7 steps), the square
//   root unit twice and the cordic unit three times (with no rotations when its
//   y operand is zero), then the result is loaded; an unreachable target goes
//   from the multiplier's check step straight to the done state
// the next transfer can come in the cycle after the result loads, so the core
//   takes a new target only once the previous result is loaded
// the result register holds while it is valid and rsp_stall is high; a finished
//   item waits in the done state until the register frees, and only then are the
//   stored angles updated, and only for a reachable target
// reset (synchronous) clears the handshakes and sets the stored angles to
//   22.859 and 90 degrees
`timescale 1ns / 1ps
module two_link_arm_inverse_kinematics_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ikin_pkg::COORD_W-1:0]   req_target_x,
   input  logic signed [ikin_pkg::COORD_W-1:0]   req_target_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_reachable,
   output logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_upper_arm_angle,
   output logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_forearm_angle,
   output logic signed [ikin_pkg::MOVE_W-1:0]    rsp_upper_arm_move,
   output logic signed [ikin_pkg::MOVE_W-1:0]    rsp_forearm_move
);
   import ikin_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_SQ1  = 8'b0000_0100,
      ST_SQ2  = 8'b0000_1000,
      ST_COR1 = 8'b0001_0000,
      ST_COR2 = 8'b0010_0000,
      ST_COR3 = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } ikin_state_type;

   localparam logic [2:0] MS_XX    = 3'd0;
   localparam logic [2:0] MS_YY    = 3'd1;
   localparam logic [2:0] MS_DY1   = 3'd2;
   localparam logic [2:0] MS_DY2   = 3'd3;
   localparam logic [2:0] MS_CHECK = 3'd4;
   localparam logic [2:0] MS_BSQ   = 3'd5;
   localparam logic [2:0] MS_DSQ   = 3'd6;

   localparam logic [RAD_W-1:0] ESQ = 50'd131533373440000;

   ikin_state_type state_ff, state_in;
   logic go_ff, go_in;
   logic [2:0] mstep_ff;

   logic signed [COORD_W-1:0] tx_ff, ty_ff;
   logic [26:0] xx_ff, yy_ff, p1_ff, p2_ff;
   logic [27:0] r2_ff;
   logic        ok_ff;
   logic [RAD_W-1:0] asq_ff, bsq_ff, dsq_ff;
   logic signed [OPND_W-1:0] a_ff, d_ff;
   logic [ROOT_W-1:0] c_ff, e_ff;
   logic signed [ZANG_W-1:0] t1_ff, t2_ff, t3_ff;
   logic signed [ANGLE_W-1:0] cur_up_ff, cur_fore_ff;

   logic rsp_valid_ff, rsp_reach_ff;
   logic signed [ANGLE_W-1:0] rsp_up_ff, rsp_fore_ff;
   logic signed [MOVE_W-1:0]  rsp_mup_ff, rsp_mfore_ff;

   logic signed [OPND_W-1:0] mul_a, mul_b, a_c, d_c;
   logic signed [2*OPND_W-1:0] prod;
   logic ok_c, accept, out_free;
   logic [RAD_W-1:0] rad;
   logic sq_start, sq_done, cor_start, cor_done;
   logic [ROOT_W-1:0] sq_root;
   logic signed [OPND_W-1:0] cy, cx;
   logic signed [ZANG_W-1:0] cor_angle;
   logic signed [27:0] up_f, fore_f, up_rnd, fore_rnd;
   logic signed [ANGLE_W-1:0] new_up, new_fore;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign a_c = $signed(r2_ff[26:0]) - 27'sd1536000;
   assign d_c = 27'sd11571200 - $signed(r2_ff[26:0]);

   // shared multiplier operand select
   always_comb begin
      unique case (mstep_ff)
         MS_XX:    begin mul_a = 27'(tx_ff); mul_b = 27'(tx_ff); end
         MS_YY:    begin mul_a = 27'(ty_ff); mul_b = 27'(ty_ff); end
         MS_DY1:   begin
            mul_a = 27'(ty_ff) - 27'sd2240; mul_b = 27'(ty_ff) - 27'sd2240;
         end
         MS_DY2:   begin
            mul_a = 27'(ty_ff) + 27'sd2560; mul_b = 27'(ty_ff) + 27'sd2560;
         end
         MS_CHECK: begin mul_a = a_c; mul_b = a_c; end
         MS_BSQ:   begin mul_a = 27'sd20070400; mul_b = $signed(r2_ff[26:0]); end
         MS_DSQ:   begin mul_a = d_c; mul_b = d_c; end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign prod = mul_a * mul_b;

   // five region tests
   assign ok_c = ({1'b0, xx_ff} + {1'b0, p1_ff} >= 28'd6553600) &&
                 (r2_ff >= 28'd1003203) &&
                 ({1'b0, xx_ff} + {1'b0, p2_ff} >= 28'd5017600) &&
                 (r2_ff <= 28'd19195614) &&
                 (ty_ff >= -14'sd1912);

   // negative radicand clamps the leg to zero
   always_comb begin
      if (state_ff == ST_SQ1) begin
         rad = (asq_ff >= bsq_ff) ? '0 : bsq_ff - asq_ff;
      end else begin
         rad = (dsq_ff >= ESQ) ? '0 : ESQ - dsq_ff;
      end
   end

   assign sq_start  = go_ff && ((state_ff == ST_SQ1) || (state_ff == ST_SQ2));
   assign cor_start = go_ff && ((state_ff == ST_COR1) || (state_ff == ST_COR2) ||
                                (state_ff == ST_COR3));

   always_comb begin
      unique case (state_ff)
         ST_COR1: begin cy = a_ff; cx = 27'({2'b00, c_ff}); end
         ST_COR2: begin cy = 27'(ty_ff); cx = 27'(tx_ff); end
         default: begin cy = 27'({2'b00, e_ff}); cx = d_ff; end
      endcase
   end

   ikin_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   ikin_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .in_y  (cy),
      .in_x  (cx),
      .done  (cor_done),
      .angle (cor_angle)
   );

   // final angles, rounded to 1/256 degree
   assign up_f     = 28'(t1_ff) - 28'(t2_ff);
   assign fore_f   = 28'sd5898240 + up_f - 28'(t3_ff);
   assign up_rnd   = up_f + 28'sd128;
   assign fore_rnd = fore_f + 28'sd128;
   assign new_up   = $signed(up_rnd[25:8]);
   assign new_fore = $signed(fore_rnd[25:8]);

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL: begin
            if (mstep_ff == MS_CHECK && !ok_c) begin
               state_in = ST_DONE;
            end else if (mstep_ff == MS_DSQ) begin
               state_in = ST_SQ1;
               go_in    = 1'b1;
            end
         end
         ST_SQ1: if (sq_done) begin state_in = ST_SQ2; go_in = 1'b1; end
         ST_SQ2: if (sq_done) begin state_in = ST_COR1; go_in = 1'b1; end
         ST_COR1: if (cor_done) begin state_in = ST_COR2; go_in = 1'b1; end
         ST_COR2: if (cor_done) begin state_in = ST_COR3; go_in = 1'b1; end
         ST_COR3: if (cor_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_up_ff    <= RESET_UPPER;
         cur_fore_ff  <= RESET_FORE;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (ok_ff) begin
               cur_up_ff   <= new_up;
               cur_fore_ff <= new_fore;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tx_ff    <= req_target_x;
         ty_ff    <= req_target_y;
         mstep_ff <= MS_XX;
      end
      if (state_ff == ST_MUL) begin
         mstep_ff <= mstep_ff + 3'd1;
         unique case (mstep_ff)
            MS_XX:  xx_ff <= prod[26:0];
            MS_YY:  yy_ff <= prod[26:0];
            MS_DY1: begin
               p1_ff <= prod[26:0];
               r2_ff <= {1'b0, xx_ff} + {1'b0, yy_ff};
            end
            MS_DY2: p2_ff <= prod[26:0];
            MS_CHECK: begin
               ok_ff  <= ok_c;
               asq_ff <= prod[RAD_W-1:0];
               a_ff   <= a_c;
            end
            MS_BSQ: bsq_ff <= prod[RAD_W-1:0];
            MS_DSQ: begin
               dsq_ff <= prod[RAD_W-1:0];
               d_ff   <= d_c;
            end
            default: ;
         endcase
      end
      if (sq_done && state_ff == ST_SQ1) c_ff <= sq_root;
      if (sq_done && state_ff == ST_SQ2) e_ff <= sq_root;
      if (cor_done && state_ff == ST_COR1) t1_ff <= cor_angle;
      if (cor_done && state_ff == ST_COR2) t2_ff <= cor_angle;
      if (cor_done && state_ff == ST_COR3) t3_ff <= cor_angle;
      if (state_ff == ST_DONE && out_free) begin
         rsp_reach_ff <= ok_ff;
         if (ok_ff) begin
            rsp_up_ff    <= new_up;
            rsp_fore_ff  <= new_fore;
            rsp_mup_ff   <= 19'(new_up) - 19'(cur_up_ff);
            rsp_mfore_ff <= 19'(new_fore) - 19'(cur_fore_ff);
         end else begin
            rsp_up_ff    <= cur_up_ff;
            rsp_fore_ff  <= cur_fore_ff;
            rsp_mup_ff   <= '0;
            rsp_mfore_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reachable       = rsp_reach_ff;
   assign rsp_upper_arm_angle = rsp_up_ff;
   assign rsp_forearm_angle   = rsp_fore_ff;
   assign rsp_upper_arm_move  = rsp_mup_ff;
   assign rsp_forearm_move    = rsp_mfore_ff;

endmodule

// ===== design/ikin_isqrt.sv =====
// iterative floor square root, two radicand bits per cycle
// depends on ikin_pkg
`timescale 1ns / 1ps
module ikin_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ikin_pkg::RAD_W-1:0]   radicand,
   output logic                         done,
   output logic [ikin_pkg::ROOT_W-1:0]  root
);
   import ikin_pkg::*;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [27:0]       rem_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [29:0]       rem_t;
   logic [29:0]       trial;

   assign rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {3'b000, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_ff  <= 28'(rem_t - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_t[27:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== design/ikin_cordic.sv =====
// vectoring cordic atan2, one rotation per cycle, 17 rotations, none when in_y is zero
// depends on ikin_pkg
`timescale 1ns / 1ps
module ikin_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [ikin_pkg::OPND_W-1:0]  in_y,
   input  logic signed [ikin_pkg::OPND_W-1:0]  in_x,
   output logic                                done,
   output logic signed [ikin_pkg::ZANG_W-1:0]  angle
);
   import ikin_pkg::*;

   logic signed [CVEC_W-1:0] x_ff, y_ff;
   logic signed [ZANG_W-1:0] z_ff;
   logic [4:0]               cnt_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic signed [CVEC_W-1:0] ys_load, xs_load, x_sh, y_sh;
   logic signed [ZANG_W-1:0] tab;

   assign ys_load = $signed({{(CVEC_W-OPND_W-20){in_y[OPND_W-1]}}, in_y, 20'b0});
   assign xs_load = $signed({{(CVEC_W-OPND_W-20){in_x[OPND_W-1]}}, in_x, 20'b0});
   assign x_sh    = x_ff >>> cnt_ff;
   assign y_sh    = y_ff >>> cnt_ff;
   assign tab     = $signed({3'b000, atan_entry(cnt_ff)});

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         cnt_ff <= '0;
         if (in_y == '0) begin
            z_ff    <= (in_x < 0) ? DEG180 : '0;
            done_ff <= 1'b1;
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= 1'b1;
            if (in_x < 0) begin
               x_ff <= -xs_load;
               y_ff <= -ys_load;
               z_ff <= (in_y > 0) ? DEG180 : -DEG180;
            end else begin
               x_ff <= xs_load;
               y_ff <= ys_load;
               z_ff <= '0;
            end
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + tab;
         end else begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - tab;
         end
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(CSTEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

// ===== design/ikin_checker.sv =====
// port-level checker for the inverse kinematics core, bound to the top level
// depends on ikin_pkg and two_link_arm_inverse_kinematics_core_assert.svh
`timescale 1ns / 1ps
`include "two_link_arm_inverse_kinematics_core_assert.svh"
module ikin_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [ikin_pkg::COORD_W-1:0]   req_target_x,
   input logic signed [ikin_pkg::COORD_W-1:0]   req_target_y,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_reachable,
   input logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_upper_arm_angle,
   input logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_forearm_angle,
   input logic signed [ikin_pkg::MOVE_W-1:0]    rsp_upper_arm_move,
   input logic signed [ikin_pkg::MOVE_W-1:0]    rsp_forearm_move
);
   import ikin_pkg::*;

   // one item at a time: a transfer closes the input side
   `IKIN_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // an unreachable target never commands a move
   `IKIN_ASSERT_NOW(a_no_move, rsp_valid && !rsp_reachable,
                    rsp_upper_arm_move == '0 && rsp_forearm_move == '0)

   // a stalled result stays valid and keeps its upper arm angle and forearm move
   `IKIN_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_upper_arm_angle) &&
                     $stable(rsp_forearm_move))

endmodule

bind two_link_arm_inverse_kinematics_core ikin_checker u_ikin_checker (.*);

// ===== dv/two_link_arm_inverse_kinematics_core_checker.sv =====
// checker for the two-link arm inverse kinematics core: watches both channels,
// predicts each result from the target and its own copy of the stored angles
// depends on ikin_pkg for widths and reset angles
`timescale 1ns / 1ps
module two_link_arm_inverse_kinematics_core_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [ikin_pkg::COORD_W-1:0]   req_target_x,
   input  logic signed [ikin_pkg::COORD_W-1:0]   req_target_y,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_reachable,
   input  logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_upper_arm_angle,
   input  logic signed [ikin_pkg::ANGLE_W-1:0]   rsp_forearm_angle,
   input  logic signed [ikin_pkg::MOVE_W-1:0]    rsp_upper_arm_move,
   input  logic signed [ikin_pkg::MOVE_W-1:0]    rsp_forearm_move,
   output int                                    fail_count,
   output int                                    pending_count,
   output int                                    checked_count,
   output int                                    reach_count
);
   import ikin_pkg::*;

   typedef struct packed {
      logic                       reachable;
      logic signed [ANGLE_W-1:0]  upper;
      logic signed [ANGLE_W-1:0]  fore;
      logic signed [MOVE_W-1:0]   upper_move;
      logic signed [MOVE_W-1:0]   fore_move;
   } joint_solution_t;

   localparam longint DEG_UNIT = 65536;
   localparam longint ARCTAN_STEP [CSTEPS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

   joint_solution_t solution_q[$];
   longint held_upper, held_fore;

   function automatic longint floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // cordic vectoring, result in 2^-16 degree
   function automatic longint arc_tangent(longint yy, longint xx);
      longint z, xs, ys;
      z = 0;
      if (yy == 0) return (xx < 0) ? 180 * DEG_UNIT : 0;
      yy = yy * 1048576;
      xx = xx * 1048576;
      if (xx < 0) begin
         z = (yy >= 0) ? 180 * DEG_UNIT : -180 * DEG_UNIT;
         xx = -xx;
         yy = -yy;
      end
      for (int i = 0; i < CSTEPS; i++) begin
         xs = xx >>> i;
         ys = yy >>> i;
         if (yy > 0) begin
            xx = xx + ys;
            yy = yy - xs;
            z = z + ARCTAN_STEP[i];
         end else begin
            xx = xx - ys;
            yy = yy + xs;
            z = z - ARCTAN_STEP[i];
         end
      end
      return z;
   endfunction

   // predicts one target and advances the stored angles when reachable
   function automatic joint_solution_t solve_target(longint x, longint y);
      joint_solution_t s;
      longint r2, dy1, dy2, a, bsq, asq, c, d, esq, dsq, e, up_f, fore_f, nu, nf;
      logic ok;
      r2 = x * x + y * y;
      dy1 = y - 2240;
      dy2 = y + 2560;
      ok = (x * x + dy1 * dy1 >= 6553600) && (r2 >= 1003203) &&
           (x * x + dy2 * dy2 >= 5017600) && (r2 <= 19195614) && (y >= -1912);
      nu = held_upper;
      nf = held_fore;
      s.upper_move = '0;
      s.fore_move = '0;
      if (ok) begin
         a = r2 - 1536000;
         bsq = 20070400 * r2;
         asq = a * a;
         c = (asq >= bsq) ? 0 : floor_root(bsq - asq);
         d = 11571200 - r2;
         esq = longint'(11468800) * 11468800;
         dsq = d * d;
         e = (dsq >= esq) ? 0 : floor_root(esq - dsq);
         up_f = arc_tangent(a, c) - arc_tangent(y, x);
         fore_f = 90 * DEG_UNIT + up_f - arc_tangent(e, d);
         nu = (up_f + 128) >>> 8;
         nf = (fore_f + 128) >>> 8;
         s.upper_move = MOVE_W'(nu - held_upper);
         s.fore_move = MOVE_W'(nf - held_fore);
         held_upper = nu;
         held_fore = nf;
      end
      s.reachable = ok;
      s.upper = ANGLE_W'(nu);
      s.fore = ANGLE_W'(nf);
      return s;
   endfunction

   always @(posedge clock) begin
      joint_solution_t want;
      joint_solution_t got;
      if (reset) begin
         held_upper <= RESET_UPPER;
         held_fore <= RESET_FORE;
         solution_q.delete();
         fail_count <= 0;
         pending_count <= 0;
         checked_count <= 0;
         reach_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            solution_q.push_back(solve_target(req_target_x, req_target_y));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_reachable, rsp_upper_arm_angle, rsp_forearm_angle,
                    rsp_upper_arm_move, rsp_forearm_move};
            checked_count <= checked_count + 1;
            if (rsp_reachable) reach_count <= reach_count + 1;
            if (solution_q.size() == 0) begin
               if (fail_count < 10) $display("result transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = solution_q.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("mismatch: exp reach %0d up %0d fore %0d mvu %0d mvf %0d,",
                        want.reachable, want.upper, want.fore, want.upper_move,
                        want.fore_move,
                        " got reach %0d up %0d fore %0d mvu %0d mvf %0d",
                        got.reachable, got.upper, got.fore,
                        got.upper_move, got.fore_move);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= solution_q.size();
      end
   end

endmodule

// ===== dv/tb_two_link_arm_inverse_kinematics_core.sv =====
// testbench top for the two-link arm inverse kinematics core: directed and
// random targets with random gaps and stalls, checked by the checker module
// depends on ikin_pkg, the core and two_link_arm_inverse_kinematics_core_checker
`timescale 1ns / 1ps
module tb_two_link_arm_inverse_kinematics_core;
   import ikin_pkg::*;

   localparam int RANDOM_ITEMS = 1630;
   localparam int IDLE_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_target_x = '0;
   logic signed [COORD_W-1:0] req_target_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_reachable;
   logic signed [ANGLE_W-1:0] rsp_upper_arm_angle, rsp_forearm_angle;
   logic signed [MOVE_W-1:0] rsp_upper_arm_move, rsp_forearm_move;
   int fail_count, pending_count, checked_count, reach_count;
   int idle_cycles = 0;
   bit long_hold = 1'b0;
   int sent_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   two_link_arm_inverse_kinematics_core u_top (.*);

   two_link_arm_inverse_kinematics_core_checker u_checker (.*);

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // result side stalls
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (long_hold) begin
            n = 400;
            long_hold = 1'b0;
         end
         if (n > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_target(input int x, input int y);
      int gap;
      gap = (sent_count % 200 < 40) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_target_x <= COORD_W'(x);
      req_target_y <= COORD_W'(y);
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   initial begin
      int dx[] = '{0, 4800, -4800, 8191, -8192, 0, 0, 4381, -4381, 0, 1002, -1500,
                   0, 3000, -3000, 2000, 100, -4000, 1, 0, 4380, -2500};
      int dy[] = '{0, 0, 0, 0, 0, 8191, -8192, 0, 0, 4381, 0, 0,
                   -1912, -1912, -1913, 3500, 4370, 1, -1, 1003, 100, 2800};
      int x, y;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      foreach (dx[i]) send_target(dx[i], dy[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400) long_hold = 1'b1;
         if (i == 800) begin
            @(negedge clock) req_valid <= 1'b0;
            wait (pending_count == 0);
         end
         if ($urandom_range(0, 9) < 7) begin
            // mostly inside the working annulus
            x = $urandom_range(0, 8800) - 4400;
            y = $urandom_range(0, 6312) - 1912;
         end else begin
            x = $urandom_range(0, 16383) - 8192;
            y = $urandom_range(0, 16383) - 8192;
         end
         send_target(x, y);
      end
      @(negedge clock) req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      $display("checked %0d results from %0d targets, %0d reachable",
               checked_count, sent_count, reach_count);
      $display("covered range extremes, region boundaries, long result stall");
      if (fail_count == 0 && pending_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/ikin_pkg.sv
design/ikin_isqrt.sv
design/ikin_cordic.sv
design/two_link_arm_inverse_kinematics_core.sv
design/ikin_checker.sv
dv/two_link_arm_inverse_kinematics_core_checker.sv
dv/tb_two_link_arm_inverse_kinematics_core.sv
